// File: sv/kmcd_pkg.sv
// Package with shared constants, codes and types for the keypad matrix change detector.
package kmcd_pkg;

   // Matrix geometry: eight ordinary rows plus the ground row.
   localparam int ROWS       = 9;
   localparam int COLS       = 8;
   localparam int SCAN_WORDS = 5;
   localparam int ROW_IDX_W  = 4;
   localparam int CHANGE_BIT = 15;

   // Index of the ground (all-rows) row.
   localparam logic [ROW_IDX_W-1:0] GROUND_ROW = ROW_IDX_W'(ROWS - 1);

   // Result status codes.
   localparam logic [1:0] STATUS_ROW_CHANGED = 2'd0;
   localparam logic [1:0] STATUS_UNSTABLE    = 2'd1;
   localparam logic [1:0] STATUS_GLITCH      = 2'd2;
   localparam logic [1:0] STATUS_NO_CHANGE   = 2'd3;

   typedef logic [COLS-1:0] row_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_EMIT,
      ST_REPORT
   } state_type;

endpackage

// File: sv/keypad_matrix_change_detector.sv
// Keypad matrix change detector: checks one scan snapshot and reports every changed row or one status word.
//
//   Port group   Direction   Handshake            Contents
//   req_*        in          req_valid/req_stall  five scan words of one snapshot
//   rsp_*        out         rsp_valid/rsp_stall  status, row, changed and pressed masks, last
//
// A snapshot is captured, each row in turn passes through the shared mask-and-compare
// unit, a decision step follows, and the rows are walked to send out the changes.
// An unstable snapshot's status word is sent from the report state, without a row scan.
// Synchronous active-high reset clears the sequencer, the output valid flag and the stored rows.
// A stalled output holds the walk; the next snapshot is taken once the walk is done,
// even while the final word still waits in the output register.
module keypad_matrix_change_detector (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [23:0]                       req_scan_word_0,
   input  logic [23:0]                       req_scan_word_1,
   input  logic [23:0]                       req_scan_word_2,
   input  logic [23:0]                       req_scan_word_3,
   input  logic [15:0]                       req_scan_word_4,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [kmcd_pkg::ROW_IDX_W-1:0]    rsp_row_index,
   output logic [kmcd_pkg::COLS-1:0]         rsp_changed_mask,
   output logic [kmcd_pkg::COLS-1:0]         rsp_pressed_mask,
   output logic                              rsp_last
);
   import kmcd_pkg::*;

   state_type            state_ff, state_in;
   logic [ROW_IDX_W-1:0] idx_ff, idx_in;
   row_type              cur_ff [ROWS];
   row_type              cur_in [ROWS];
   row_type              prev_ff [ROWS];
   row_type              prev_in [ROWS];
   logic [ROWS-1:0]      diff_ff, diff_in;
   row_type              common_ff, common_in;
   logic [1:0]           report_ff, report_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [ROW_IDX_W-1:0] rsp_row_ff, rsp_row_in;
   row_type              rsp_changed_ff, rsp_changed_in;
   row_type              rsp_pressed_ff, rsp_pressed_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 slot_free;
   logic                 unstable;
   row_type              row_sel;
   row_type              masked;
   logic [ROWS-1:0]      higher_diff;

   // The change bit of every word must match that of the first word.
   assign unstable = (req_scan_word_1[CHANGE_BIT] != req_scan_word_0[CHANGE_BIT]) ||
                     (req_scan_word_2[CHANGE_BIT] != req_scan_word_0[CHANGE_BIT]) ||
                     (req_scan_word_3[CHANGE_BIT] != req_scan_word_0[CHANGE_BIT]) ||
                     (req_scan_word_4[CHANGE_BIT] != req_scan_word_0[CHANGE_BIT]);

   // The output register can take a word when empty or when its word leaves now.
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Shared unit: select one row, strip the ground columns from ordinary rows.
   assign row_sel = cur_ff[idx_ff];
   assign masked  = (idx_ff == GROUND_ROW) ? row_sel : (row_sel & ~cur_ff[GROUND_ROW]);

   // Changed rows above the current one; none left means this word is the last.
   assign higher_diff = (diff_ff >> idx_ff) >> 1;

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < ROWS; r++) begin
            prev_ff[r] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
      end
      idx_ff         <= idx_in;
      cur_ff         <= cur_in;
      diff_ff        <= diff_in;
      common_ff      <= common_in;
      report_ff      <= report_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_row_ff     <= rsp_row_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_pressed_ff <= rsp_pressed_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // Sequencer: next state and datapath controls.
   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      diff_in        = diff_ff;
      common_in      = common_ff;
      report_in      = report_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_row_in     = rsp_row_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_pressed_in = rsp_pressed_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur_in[0]          = ~req_scan_word_0[7:0];
               cur_in[1]          = ~req_scan_word_0[23:16];
               cur_in[2]          = ~req_scan_word_1[7:0];
               cur_in[3]          = ~req_scan_word_1[23:16];
               cur_in[4]          = ~req_scan_word_2[7:0];
               cur_in[5]          = ~req_scan_word_2[23:16];
               cur_in[6]          = ~req_scan_word_3[7:0];
               cur_in[7]          = ~req_scan_word_3[23:16];
               cur_in[GROUND_ROW] = ~req_scan_word_4[7:0];
               idx_in             = '0;
               common_in          = '1;
               diff_in            = '0;
               if (unstable) begin
                  report_in = STATUS_UNSTABLE;
                  state_in  = ST_REPORT;
               end else begin
                  state_in  = ST_SCAN;
               end
            end
         end

         // One row per cycle: shared-column AND, ground strip, compare with stored row.
         ST_SCAN: begin
            if (idx_ff != GROUND_ROW) begin
               common_in      = common_ff & row_sel;
               cur_in[idx_ff] = masked;
            end
            diff_in[idx_ff] = (masked != prev_ff[idx_ff]);
            if (idx_ff == GROUND_ROW) begin
               state_in = ST_DECIDE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_DECIDE: begin
            idx_in = '0;
            if ((cur_ff[GROUND_ROW] & common_ff) != common_ff) begin
               report_in = STATUS_GLITCH;
               state_in  = ST_REPORT;
            end else if (diff_ff == '0) begin
               report_in = STATUS_NO_CHANGE;
               state_in  = ST_REPORT;
            end else begin
               state_in  = ST_EMIT;
            end
         end

         // Walk the rows, sending a word for each changed one and updating the stored row.
         ST_EMIT: begin
            if (!diff_ff[idx_ff] || slot_free) begin
               if (diff_ff[idx_ff]) begin
                  rsp_valid_in   = 1'b1;
                  rsp_status_in  = STATUS_ROW_CHANGED;
                  rsp_row_in     = idx_ff;
                  rsp_changed_in = cur_ff[idx_ff] ^ prev_ff[idx_ff];
                  rsp_pressed_in = cur_ff[idx_ff];
                  rsp_last_in    = (higher_diff == '0);
                  prev_in[idx_ff] = cur_ff[idx_ff];
               end
               if (idx_ff == GROUND_ROW) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         // Single status word for unstable, glitch and no-change snapshots.
         ST_REPORT: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = report_ff;
               rsp_row_in     = '0;
               rsp_changed_in = '0;
               rsp_pressed_in = '0;
               rsp_last_in    = 1'b1;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_row_index    = rsp_row_ff;
   assign rsp_changed_mask = rsp_changed_ff;
   assign rsp_pressed_mask = rsp_pressed_ff;
   assign rsp_last         = rsp_last_ff;

   // A status word other than a row change is always the only word and carries no masks.
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_ROW_CHANGED) |->
         rsp_last && (rsp_row_index == '0) && (rsp_changed_mask == '0) &&
         (rsp_pressed_mask == '0))
      else $error("status word carries row data");

   // A row change word names a real row and a nonzero change.
   a_row_change: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_ROW_CHANGED) |->
         (rsp_row_index <= GROUND_ROW) && (rsp_changed_mask != '0))
      else $error("row change word out of range or empty");

   // A taken snapshot closes the input until the sequencer is done.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input open right after accept");

   // The row walk never runs past the ground row.
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) || (state_ff == ST_EMIT) |-> (idx_ff <= GROUND_ROW))
      else $error("row index past ground row");

endmodule
